FILE: sv/phdq_pkg.sv
// package for the packet hold and duplicate filter queue
// word types, reject causes, entry status codes and register indexes; no dependencies
package phdq_pkg;

    typedef struct packed {
        logic        opcode;
        logic [31:0] packet_hash;
        logic        packet_valid;
        logic        routed_ok;
        logic        path_used;
        logic [9:0]  advance_ms;
    } in_word_t;

    typedef struct packed {
        logic [31:0] entry_number;
        logic        accepted;
        logic [2:0]  reject_cause;
        logic [31:0] age_ms;
        logic        last;
    } out_word_t;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_DUP       = 3'd1;
    localparam logic [2:0] CAUSE_AGE       = 3'd2;
    localparam logic [2:0] CAUSE_DIRECT    = 3'd3;
    localparam logic [2:0] CAUSE_NONROUTED = 3'd4;
    localparam logic [2:0] CAUSE_INVALID   = 3'd5;
    localparam logic [2:0] CAUSE_FULL      = 3'd6;

    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic [2:0] REG_HOLD_TIME  = 3'd0;
    localparam logic [2:0] REG_MAX_ACCEPT = 3'd1;
    localparam logic [2:0] REG_MAX_KEEP   = 3'd2;
    localparam logic [2:0] REG_DEDUPE_WIN = 3'd3;
    localparam logic [2:0] REG_DIRECT     = 3'd4;

    localparam logic [31:0] MAX_ACCEPT_RESET = 32'd5000;
    localparam logic [31:0] MAX_KEEP_RESET   = 32'd60000;
    localparam logic [31:0] DEDUPE_RESET     = 32'd30000;

    localparam logic [9:0]  STEP_MS = 10'd100;
    localparam logic [31:0] AGE_MAX = 32'hFFFF_FFFF;

endpackage

FILE: sv/packet_hold_dedupe_queue.sv
// Packet hold and duplicate filter queue. Recent packets sit in a FIFO held in one
// synchronous memory (one read port, one write port, registered read data). A valid
// packet word appends an entry and runs an update pass (an invalid one, or one that
// finds the queue full, gets a single reject); a tick word ages all entries in steps
// of at most 100 ms with one update pass per step. An update pass drops stale head
// entries and then visits every entry, with a write for each decision; a pending
// entry that reaches the duplicate check scans the queue. A stalled output holds the
// pass at its next decision. One word is handled at a time; results leave through
// an output register, the last one flagged with last.
// depends on phdq_pkg
module packet_hold_dedupe_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int HASH_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  phdq_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output phdq_pkg::out_word_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import phdq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef struct packed {
        logic [HASH_BITS-1:0] hash;
        logic [31:0]          number;
        logic [31:0]          age;
        logic [1:0]           status;
        logic                 routed;
        logic                 path_used;
    } entry_t;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_TICK     = 12'b0000_0000_0010,
        S_AGE_RD   = 12'b0000_0000_0100,
        S_AGE_WR   = 12'b0000_0000_1000,
        S_DROP_RD  = 12'b0000_0001_0000,
        S_DROP_CHK = 12'b0000_0010_0000,
        S_SCAN_RD  = 12'b0000_0100_0000,
        S_SCAN_CHK = 12'b0000_1000_0000,
        S_DUP_RD   = 12'b0001_0000_0000,
        S_DUP_CHK  = 12'b0010_0000_0000,
        S_DEC_WR   = 12'b0100_0000_0000,
        S_FLUSH    = 12'b1000_0000_0000
    } state_t;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    state_t         state_reg, state_next;
    logic [IW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [31:0]    arrival_reg, arrival_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  dpos_reg, dpos_next;
    logic [9:0]     adv_reg, adv_next;
    logic [9:0]     add_reg, add_next;
    logic           tick_reg, tick_next;
    entry_t         cur_reg, cur_next;
    logic [2:0]     cause_reg, cause_next;
    out_word_t      held_reg, held_next;
    logic           held_valid_reg, held_valid_next;
    out_word_t      out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    logic [31:0] hold_reg, accept_reg, keep_reg, window_reg;
    logic        direct_reg;

    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    entry_t        wr_data;

    logic [IW-1:0]          pos_slot, dpos_slot, tail_slot;
    logic [IW:0]            pos_sum, dpos_sum, tail_sum;
    logic                   out_free;
    logic [32:0]            age_sum;
    logic [HASH_BITS+31:0]  hash_ext;

    // slot of a fifo position, head plus position wrapped at the depth
    assign pos_sum   = (IW+1)'(head_reg) + (IW+1)'(pos_reg);
    assign dpos_sum  = (IW+1)'(head_reg) + (IW+1)'(dpos_reg);
    assign tail_sum  = (IW+1)'(head_reg) + (IW+1)'(count_reg);
    assign pos_slot  = (pos_sum  >= (IW+1)'(QUEUE_DEPTH)) ?
                       IW'(pos_sum  - (IW+1)'(QUEUE_DEPTH)) : IW'(pos_sum);
    assign dpos_slot = (dpos_sum >= (IW+1)'(QUEUE_DEPTH)) ?
                       IW'(dpos_sum - (IW+1)'(QUEUE_DEPTH)) : IW'(dpos_sum);
    assign tail_slot = (tail_sum >= (IW+1)'(QUEUE_DEPTH)) ?
                       IW'(tail_sum - (IW+1)'(QUEUE_DEPTH)) : IW'(tail_sum);

    assign out_free  = !out_valid_reg || out_ready;
    assign age_sum   = {1'b0, rd_data_reg.age} + {23'd0, add_reg};
    assign hash_ext  = {{HASH_BITS{1'b0}}, in_data.packet_hash};

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= '0;
            accept_reg <= MAX_ACCEPT_RESET;
            keep_reg   <= MAX_KEEP_RESET;
            window_reg <= DEDUPE_RESET;
            direct_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HOLD_TIME:  hold_reg   <= cfg_data;
                REG_MAX_ACCEPT: accept_reg <= cfg_data;
                REG_MAX_KEEP:   keep_reg   <= cfg_data;
                REG_DEDUPE_WIN: window_reg <= cfg_data;
                REG_DIRECT:     direct_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        arrival_next    = arrival_reg;
        pos_next        = pos_reg;
        dpos_next       = dpos_reg;
        adv_next        = adv_reg;
        add_next        = add_reg;
        tick_next       = tick_reg;
        cur_next        = cur_reg;
        cause_next      = cause_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        rd_en           = 1'b0;
        rd_addr         = pos_slot;
        wr_en           = 1'b0;
        wr_addr         = pos_slot;
        wr_data         = rd_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tick_next = (in_data.opcode == OP_TICK);
                    if (in_data.opcode == OP_TICK)
                    begin
                        adv_next   = in_data.advance_ms;
                        state_next = (in_data.advance_ms == '0) ? S_IDLE : S_TICK;
                    end
                    else if (!in_data.packet_valid || count_reg == DEPTH_C)
                    begin
                        held_next.entry_number = '0;
                        held_next.accepted     = 1'b0;
                        held_next.reject_cause = in_data.packet_valid ? CAUSE_FULL
                                                                      : CAUSE_INVALID;
                        held_next.age_ms       = '0;
                        held_next.last         = 1'b0;
                        held_valid_next        = 1'b1;
                        state_next             = S_FLUSH;
                    end
                    else
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = tail_slot;
                        wr_data.hash      = hash_ext[HASH_BITS-1:0];
                        wr_data.number    = arrival_reg;
                        wr_data.age       = '0;
                        wr_data.status    = ST_PENDING;
                        wr_data.routed    = in_data.routed_ok;
                        wr_data.path_used = in_data.path_used;
                        count_next        = count_reg + 1'b1;
                        arrival_next      = arrival_reg + 32'd1;
                        state_next        = S_DROP_RD;
                    end
                end
            end

            S_TICK:
            begin
                add_next   = (adv_reg >= STEP_MS) ? STEP_MS : adv_reg;
                adv_next   = adv_reg - ((adv_reg >= STEP_MS) ? STEP_MS : adv_reg);
                pos_next   = '0;
                state_next = S_AGE_RD;
            end

            S_AGE_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    state_next = S_DROP_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_AGE_WR;
                end
            end

            S_AGE_WR:
            begin
                wr_en       = 1'b1;
                wr_data.age = age_sum[32] ? AGE_MAX : age_sum[31:0];
                pos_next    = pos_reg + 1'b1;
                state_next  = S_AGE_RD;
            end

            S_DROP_RD:
            begin
                pos_next = '0;
                if (count_reg == '0)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_DROP_CHK;
                end
            end

            S_DROP_CHK:
            begin
                if (rd_data_reg.age >= keep_reg)
                begin
                    head_next  = (head_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_DROP_RD;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    state_next = (tick_reg && adv_reg != '0) ? S_TICK : S_FLUSH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                cur_next = rd_data_reg;
                if (rd_data_reg.status != ST_PENDING)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else if (!rd_data_reg.routed)
                begin
                    cause_next = CAUSE_NONROUTED;
                    state_next = S_DEC_WR;
                end
                else if (hold_reg != '0 && rd_data_reg.age <= hold_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else if (rd_data_reg.age >= accept_reg)
                begin
                    cause_next = CAUSE_AGE;
                    state_next = S_DEC_WR;
                end
                else if (rd_data_reg.path_used && direct_reg)
                begin
                    cause_next = CAUSE_DIRECT;
                    state_next = S_DEC_WR;
                end
                else
                begin
                    dpos_next  = '0;
                    state_next = S_DUP_RD;
                end
            end

            S_DUP_RD:
            begin
                if (dpos_reg == count_reg)
                begin
                    cause_next = CAUSE_NONE;
                    state_next = S_DEC_WR;
                end
                else if (dpos_reg == pos_reg)
                begin
                    dpos_next = dpos_reg + 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = dpos_slot;
                    state_next = S_DUP_CHK;
                end
            end

            S_DUP_CHK:
            begin
                if (rd_data_reg.hash == cur_reg.hash && rd_data_reg.status != ST_REJECTED &&
                    rd_data_reg.age < window_reg)
                begin
                    cause_next = CAUSE_DUP;
                    state_next = S_DEC_WR;
                end
                else
                begin
                    dpos_next  = dpos_reg + 1'b1;
                    state_next = S_DUP_RD;
                end
            end

            S_DEC_WR:
            begin
                // the previous result goes out only once a newer one shows it was not last
                if (!held_valid_reg || out_free)
                begin
                    if (held_valid_reg)
                    begin
                        out_next       = held_reg;
                        out_valid_next = 1'b1;
                    end
                    wr_en                  = 1'b1;
                    wr_data                = cur_reg;
                    wr_data.status         = (cause_reg == CAUSE_NONE) ? ST_ACCEPTED
                                                                       : ST_REJECTED;
                    held_next.entry_number = cur_reg.number;
                    held_next.accepted     = (cause_reg == CAUSE_NONE);
                    held_next.reject_cause = cause_reg;
                    held_next.age_ms       = cur_reg.age;
                    held_next.last         = 1'b0;
                    held_valid_next        = 1'b1;
                    pos_next               = pos_reg + 1'b1;
                    state_next             = S_SCAN_RD;
                end
            end

            S_FLUSH:
            begin
                if (!held_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = held_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            arrival_reg    <= '0;
            pos_reg        <= '0;
            dpos_reg       <= '0;
            adv_reg        <= '0;
            tick_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            arrival_reg    <= arrival_next;
            pos_reg        <= pos_next;
            dpos_reg       <= dpos_next;
            adv_reg        <= adv_next;
            tick_reg       <= tick_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_reg   <= add_next;
        cur_reg   <= cur_next;
        cause_reg <= cause_next;
        held_reg  <= held_next;
        out_reg   <= out_next;
    end

endmodule

FILE: verif/packet_hold_dedupe_queue_tb.sv
// testbench for packet_hold_dedupe_queue: directed table then random words over several
// register settings, every result checked against a table row or a local queue predictor
// depends on phdq_pkg and packet_hold_dedupe_queue
`timescale 1ns / 100ps

module packet_hold_dedupe_queue_tb;
    import phdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int SETTLE      = 8000;    // worst-case tick on a full queue, with margin
    localparam int STALL_LIMIT = 200000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t result;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    logic [31:0] q_hash [DEPTH];
    logic [31:0] q_num  [DEPTH];
    logic [31:0] q_age  [DEPTH];
    logic [1:0]  q_st   [DEPTH];
    bit          q_rt   [DEPTH];
    bit          q_pu   [DEPTH];
    int          q_head;
    int          q_fill;
    logic [31:0] arrivals;
    logic [31:0] hold_ms, accept_ms, keep_ms, window_ms;
    bit          direct_set;

    out_word_t   step_results[$];
    out_word_t   pending_results[$];
    dir_row_t    dir_rows[$];

    int  mismatches;
    int  checked;
    int  words_sent;
    bit  calm;
    bit  hold_rx;
    int  quiet_cycles;

    packet_hold_dedupe_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void decide_slot(int s, logic [2:0] cause);
        out_word_t r;
        q_st[s] = (cause == CAUSE_NONE) ? ST_ACCEPTED : ST_REJECTED;
        r.entry_number = q_num[s];
        r.accepted     = (cause == CAUSE_NONE);
        r.reject_cause = cause;
        r.age_ms       = q_age[s];
        r.last         = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic bit dup_seen(int self);
        int s;
        for (int i = q_fill - 1; i >= 0; i--)
        begin
            s = (q_head + i) % DEPTH;
            if (s != self && q_hash[s] == q_hash[self] && q_st[s] != ST_REJECTED
                    && q_age[s] < window_ms)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void update_queue();
        int s;
        while (q_fill > 0 && q_age[q_head] >= keep_ms)
        begin
            q_head = (q_head + 1) % DEPTH;
            q_fill--;
        end
        for (int i = 0; i < q_fill; i++)
        begin
            s = (q_head + i) % DEPTH;
            if (q_st[s] != ST_PENDING)
                continue;
            if (!q_rt[s])
                decide_slot(s, CAUSE_NONROUTED);
            else if (hold_ms != 0 && q_age[s] <= hold_ms)
                continue;
            else if (q_age[s] >= accept_ms)
                decide_slot(s, CAUSE_AGE);
            else if (q_pu[s] && direct_set)
                decide_slot(s, CAUSE_DIRECT);
            else if (dup_seen(s))
                decide_slot(s, CAUSE_DUP);
            else
                decide_slot(s, CAUSE_NONE);
        end
    endfunction

    function automatic void age_queue(logic [31:0] add);
        int s;
        for (int i = 0; i < q_fill; i++)
        begin
            s = (q_head + i) % DEPTH;
            q_age[s] = (q_age[s] > AGE_MAX - add) ? AGE_MAX : q_age[s] + add;
        end
    endfunction

    // fills step_results with the decisions one word causes
    function automatic void predict_decisions(in_word_t w);
        int s;
        int steps;
        int rest;
        step_results.delete();
        if (w.opcode == OP_PACKET)
        begin
            if (!w.packet_valid)
                step_results.insert(step_results.size(),
                                    out_word_t'{32'd0, 1'b0, CAUSE_INVALID, 32'd0, 1'b0});
            else if (q_fill >= DEPTH)
                step_results.insert(step_results.size(),
                                    out_word_t'{32'd0, 1'b0, CAUSE_FULL, 32'd0, 1'b0});
            else
            begin
                s = (q_head + q_fill) % DEPTH;
                q_hash[s] = w.packet_hash;
                q_num[s]  = arrivals;
                q_age[s]  = 32'd0;
                q_st[s]   = ST_PENDING;
                q_rt[s]   = w.routed_ok;
                q_pu[s]   = w.path_used;
                q_fill++;
                arrivals++;
                update_queue();
            end
        end
        else
        begin
            steps = w.advance_ms / STEP_MS;
            rest  = w.advance_ms % STEP_MS;
            for (int k = 0; k < steps; k++)
            begin
                age_queue(32'(STEP_MS));
                update_queue();
            end
            if (rest > 0)
            begin
                age_queue(32'(rest));
                update_queue();
            end
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    function automatic in_word_t packet_word(logic [31:0] h, bit ok, bit rt, bit pu);
        in_word_t w;
        w = '0;
        w.opcode       = OP_PACKET;
        w.packet_hash  = h;
        w.packet_valid = ok;
        w.routed_ok    = rt;
        w.path_used    = pu;
        w.advance_ms   = 10'($urandom);
        return w;
    endfunction

    function automatic in_word_t tick_word(logic [9:0] adv);
        in_word_t w;
        w = in_word_t'({$urandom, $urandom});
        w.opcode     = OP_TICK;
        w.advance_ms = adv;
        return w;
    endfunction

    function automatic void add_row(in_word_t w, bit typed, out_word_t r);
        dir_rows.insert(dir_rows.size(), dir_row_t'{w, typed, r});
    endfunction

    function automatic in_word_t random_word();
        logic [31:0] h;
        logic [9:0]  adv;
        if ($urandom_range(99) < 60)
        begin
            // small hash pool so duplicates are common
            h = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(3)) * 32'h9E37_79B9;
            return packet_word(h, $urandom_range(99) < 90, $urandom_range(99) < 85,
                               $urandom_range(99) < 30);
        end
        case ($urandom_range(5))
            0:       adv = 10'd0;
            1:       adv = 10'd1000;
            2:       adv = 10'($urandom_range(10) * 100);
            default: adv = 10'($urandom_range(1000));
        endcase
        return tick_word(adv);
    endfunction

    task automatic send_word(in_word_t w);
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_decisions(w);
        foreach (step_results[i])
            pending_results.insert(pending_results.size(), step_results[i]);
        words_sent++;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_HOLD_TIME:  hold_ms    = value;
            REG_MAX_ACCEPT: accept_ms  = value;
            REG_MAX_KEEP:   keep_ms    = value;
            REG_DEDUPE_WIN: window_ms  = value;
            REG_DIRECT:     direct_set = value[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] h, logic [31:0] a, logic [31:0] k,
                            logic [31:0] win, logic [31:0] d);
        drain_and_settle();
        write_reg(REG_HOLD_TIME, h);
        write_reg(REG_MAX_ACCEPT, a);
        write_reg(REG_MAX_KEEP, k);
        write_reg(REG_DEDUPE_WIN, win);
        write_reg(REG_DIRECT, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_word(random_word());
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: number %0d cause %0d age %0d",
                                 out_data.entry_number, out_data.reject_cause, out_data.age_ms);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.entry_number !== want.entry_number
                            || out_data.accepted !== want.accepted
                            || out_data.reject_cause !== want.reject_cause
                            || out_data.age_ms !== want.age_ms
                            || out_data.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: want num %0d acc %0d cause %0d",
                                      " age %0d last %0d, got num %0d acc %0d cause %0d",
                                      " age %0d last %0d"},
                                     want.entry_number, want.accepted, want.reject_cause,
                                     want.age_ms, want.last, out_data.entry_number,
                                     out_data.accepted, out_data.reject_cause,
                                     out_data.age_ms, out_data.last);
                    end
                end
            end
            out_ready <= hold_rx ? 1'b0 : (calm ? 1'b1 : ($urandom_range(99) >= 18));
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        out_word_t no_result;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        checked      = 0;
        words_sent   = 0;
        calm         = 1'b0;
        hold_rx      = 1'b0;
        quiet_cycles = 0;
        q_head       = 0;
        q_fill       = 0;
        arrivals     = '0;
        hold_ms      = 32'd0;
        accept_ms    = MAX_ACCEPT_RESET;
        keep_ms      = MAX_KEEP_RESET;
        window_ms    = DEDUPE_RESET;
        direct_set   = 1'b0;
        no_result    = '0;

        // directed table, reset settings
        add_row(packet_word(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1), 1'b1,
                '{32'd0, 1'b0, CAUSE_INVALID, 32'd0, 1'b1});
        add_row(packet_word(32'h0000_0000, 1'b1, 1'b1, 1'b0), 1'b1,
                '{32'd0, 1'b1, CAUSE_NONE, 32'd0, 1'b1});
        add_row(packet_word(32'h1234_5678, 1'b1, 1'b0, 1'b0), 1'b1,
                '{32'd1, 1'b0, CAUSE_NONROUTED, 32'd0, 1'b1});
        add_row(packet_word(32'h0000_0000, 1'b1, 1'b1, 1'b1), 1'b0, no_result);
        add_row(packet_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1), 1'b0, no_result);
        add_row(packet_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0), 1'b0, no_result);
        add_row(tick_word(10'd0), 1'b0, no_result);
        add_row(tick_word(10'd1000), 1'b0, no_result);
        add_row(tick_word(10'd150), 1'b0, no_result);
        // five entries so far, eleven more fill the queue
        for (int i = 0; i < 11; i++)
            add_row(packet_word(32'hA5A5_0000 + i, 1'b1, 1'b1, i[0]), 1'b0, no_result);
        add_row(packet_word(32'h5A5A_5A5A, 1'b1, 1'b1, 1'b0), 1'b1,
                '{32'd0, 1'b0, CAUSE_FULL, 32'd0, 1'b1});
        add_row(tick_word(10'd999), 1'b0, no_result);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].word);
            if (dir_rows[i].typed)
            begin
                repeat (step_results.size()) void'(pending_results.pop_back());
                pending_results.insert(pending_results.size(), dir_rows[i].result);
            end
        end

        // short windows so entries age out and decisions mix
        set_regs(32'd0, 32'd800, 32'd2500, 32'd1200, 32'd1);
        write_reg(REG_UNUSED, $urandom);     // unused index, no effect
        cfg_valid <= 1'b0;
        run_random(40);

        set_regs(32'd300, 32'd2000, 32'd4000, 32'd3000, 32'd0);
        fork
            begin
                hold_rx = 1'b1;
                repeat (3000) @(posedge clk);
                hold_rx = 1'b0;
            end
        join_none
        run_random(45);

        set_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_random(35);

        set_regs(AGE_MAX, AGE_MAX, AGE_MAX, AGE_MAX, 32'd1);
        run_random(35);

        set_regs(32'd150, 32'd1500, 32'd6000, 32'd5000, 32'd1);
        calm = 1'b1;
        run_random(30);
        calm = 1'b0;
        // let everything drain before offering more
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        @(posedge clk);
        run_random(45);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d input words over six register settings, checked %0d results",
                 words_sent, checked);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
